@@ design/complex_arithmetic_unit_macros.svh @@
// Assertion helpers shared by the complex arithmetic unit.
`ifndef COMPLEX_ARITHMETIC_UNIT_MACROS_SVH
`define COMPLEX_ARITHMETIC_UNIT_MACROS_SVH

// A property that must hold on every clock edge outside reset.
`define CAU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// An implication checked on every clock edge outside reset.
`define CAU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

@@ design/cau_pkg.sv @@
`timescale 1ns / 1ps
package cau_pkg;
  localparam int PORT_W         = 32;
  localparam int REQ_W          = 3;
  localparam int STAT_W         = 2;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  localparam logic [REQ_W-1:0] OP_ADD   = 3'd0;
  localparam logic [REQ_W-1:0] OP_SUB   = 3'd1;
  localparam logic [REQ_W-1:0] OP_MUL   = 3'd2;
  localparam logic [REQ_W-1:0] OP_DIV   = 3'd3;
  localparam logic [REQ_W-1:0] OP_CONJ  = 3'd4;
  localparam logic [REQ_W-1:0] OP_MODSQ = 3'd5;

  localparam logic [STAT_W-1:0] ST_OK  = 2'd0;
  localparam logic [STAT_W-1:0] ST_SAT = 2'd1;
  localparam logic [STAT_W-1:0] ST_DZ  = 2'd2;

  typedef struct packed {
    logic              is_div;
    logic              dz;
    logic              neg_re;
    logic              neg_im;
    logic [STAT_W-1:0] status;
  } cau_ctl_t;
endpackage

@@ design/cau_front.sv @@
`timescale 1ns / 1ps
module cau_front #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic [cau_pkg::REQ_W-1:0]           in_req_type,
  input  logic signed [cau_pkg::PORT_W-1:0]   in_a_re,
  input  logic signed [cau_pkg::PORT_W-1:0]   in_a_im,
  input  logic signed [cau_pkg::PORT_W-1:0]   in_b_re,
  input  logic signed [cau_pkg::PORT_W-1:0]   in_b_im,
  output logic                                f_valid,
  output cau_pkg::cau_ctl_t                   f_ctl,
  output logic [DATA_WIDTH-1:0]               f_res_re,
  output logic [DATA_WIDTH-1:0]               f_res_im,
  output logic [2*DATA_WIDTH-1:0]             f_num_re,
  output logic [2*DATA_WIDTH-1:0]             f_num_im,
  output logic [2*DATA_WIDTH-1:0]             f_den
);
  import cau_pkg::*;

  localparam int W = DATA_WIDTH;
  localparam int P = 2 * DATA_WIDTH;
  localparam int S = 2 * DATA_WIDTH + 1;

  // Stage 1: operands.
  logic                 s1_v_r;
  logic [REQ_W-1:0]     s1_op_r;
  logic signed [W-1:0]  s1_ar_r, s1_ai_r, s1_br_r, s1_bi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= in_valid;
    end
    s1_op_r <= in_req_type;
    s1_ar_r <= in_a_re[W-1:0];
    s1_ai_r <= in_a_im[W-1:0];
    s1_br_r <= in_b_re[W-1:0];
    s1_bi_r <= in_b_im[W-1:0];
  end

  // Stage 2: products. The squared pair serves both |B|^2 and |A|^2.
  logic signed [W-1:0] mx, my;
  assign mx = (s1_op_r == OP_MODSQ) ? s1_ar_r : s1_br_r;
  assign my = (s1_op_r == OP_MODSQ) ? s1_ai_r : s1_bi_r;

  logic                s2_v_r;
  logic [REQ_W-1:0]    s2_op_r;
  logic signed [W-1:0] s2_ar_r, s2_ai_r, s2_br_r, s2_bi_r;
  logic signed [P-1:0] s2_rr_r, s2_ii_r, s2_ri_r, s2_ir_r, s2_xx_r, s2_yy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else begin
      s2_v_r <= s1_v_r;
    end
    s2_op_r <= s1_op_r;
    s2_ar_r <= s1_ar_r;
    s2_ai_r <= s1_ai_r;
    s2_br_r <= s1_br_r;
    s2_bi_r <= s1_bi_r;
    s2_rr_r <= s1_ar_r * s1_br_r;
    s2_ii_r <= s1_ai_r * s1_bi_r;
    s2_ri_r <= s1_ar_r * s1_bi_r;
    s2_ir_r <= s1_ai_r * s1_br_r;
    s2_xx_r <= mx * mx;
    s2_yy_r <= my * my;
  end

  // Stage 3: sums at full width.
  logic signed [S-1:0] e_ar, e_ai, e_br, e_bi;
  logic signed [S-1:0] e_rr, e_ii, e_ri, e_ir, e_xx, e_yy;
  logic signed [S-1:0] z_re_nxt, z_im_nxt;

  assign e_ar = S'(s2_ar_r);
  assign e_ai = S'(s2_ai_r);
  assign e_br = S'(s2_br_r);
  assign e_bi = S'(s2_bi_r);
  assign e_rr = S'(s2_rr_r);
  assign e_ii = S'(s2_ii_r);
  assign e_ri = S'(s2_ri_r);
  assign e_ir = S'(s2_ir_r);
  assign e_xx = S'(s2_xx_r);
  assign e_yy = S'(s2_yy_r);

  always_comb begin
    z_re_nxt = '0;
    z_im_nxt = '0;
    unique case (s2_op_r)
      OP_ADD: begin
        z_re_nxt = e_ar + e_br;
        z_im_nxt = e_ai + e_bi;
      end
      OP_SUB: begin
        z_re_nxt = e_ar - e_br;
        z_im_nxt = e_ai - e_bi;
      end
      OP_MUL: begin
        z_re_nxt = (e_rr - e_ii) >>> FRAC_BITS;
        z_im_nxt = (e_ri + e_ir) >>> FRAC_BITS;
      end
      OP_CONJ: begin
        z_re_nxt = e_ar;
        z_im_nxt = -e_ai;
      end
      OP_MODSQ: begin
        z_re_nxt = (e_xx + e_yy) >>> FRAC_BITS;
      end
      default: begin
      end
    endcase
  end

  logic                s3_v_r;
  logic [REQ_W-1:0]    s3_op_r;
  logic signed [S-1:0] s3_zre_r, s3_zim_r, s3_nre_r, s3_nim_r;
  logic [P-1:0]        s3_den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else begin
      s3_v_r <= s2_v_r;
    end
    s3_op_r  <= s2_op_r;
    s3_zre_r <= z_re_nxt;
    s3_zim_r <= z_im_nxt;
    s3_nre_r <= e_rr + e_ii;
    s3_nim_r <= e_ir - e_ri;
    s3_den_r <= P'(e_xx + e_yy);
  end

  // Stage 4: saturate the direct results and take divider magnitudes.
  function automatic logic [W:0] sat_w(input logic signed [S-1:0] v);
    logic [W:0] r;
    if ((&v[S-1:W-1]) || !(|v[S-1:W-1])) begin
      r = {1'b0, v[W-1:0]};
    end else if (v[S-1]) begin
      r = {2'b11, {(W-1){1'b0}}};
    end else begin
      r = {2'b10, {(W-1){1'b1}}};
    end
    return r;
  endfunction

  logic [W:0]          sat_re, sat_im;
  logic signed [S-1:0] abs_re, abs_im;
  cau_ctl_t            ctl_nxt;

  assign sat_re = sat_w(s3_zre_r);
  assign sat_im = sat_w(s3_zim_r);
  assign abs_re = s3_nre_r[S-1] ? -s3_nre_r : s3_nre_r;
  assign abs_im = s3_nim_r[S-1] ? -s3_nim_r : s3_nim_r;

  always_comb begin
    ctl_nxt.is_div = (s3_op_r == OP_DIV);
    ctl_nxt.dz     = (s3_den_r == '0);
    ctl_nxt.neg_re = s3_nre_r[S-1];
    ctl_nxt.neg_im = s3_nim_r[S-1];
    ctl_nxt.status = (sat_re[W] || sat_im[W]) ? ST_SAT : ST_OK;
  end

  logic          s4_v_r;
  cau_ctl_t      s4_ctl_r;
  logic [W-1:0]  s4_re_r, s4_im_r;
  logic [P-1:0]  s4_nre_r, s4_nim_r, s4_den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else begin
      s4_v_r <= s3_v_r;
    end
    s4_ctl_r <= ctl_nxt;
    s4_re_r  <= sat_re[W-1:0];
    s4_im_r  <= sat_im[W-1:0];
    s4_nre_r <= abs_re[P-1:0];
    s4_nim_r <= abs_im[P-1:0];
    s4_den_r <= s3_den_r;
  end

  assign f_valid  = s4_v_r;
  assign f_ctl    = s4_ctl_r;
  assign f_res_re = s4_re_r;
  assign f_res_im = s4_im_r;
  assign f_num_re = s4_nre_r;
  assign f_num_im = s4_nim_r;
  assign f_den    = s4_den_r;
endmodule

@@ design/cau_divider.sv @@
`timescale 1ns / 1ps
module cau_divider #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16,
  parameter int TAG_W      = 8
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 d_valid,
  input  logic [2*DATA_WIDTH-1:0]              d_num_re,
  input  logic [2*DATA_WIDTH-1:0]              d_num_im,
  input  logic [2*DATA_WIDTH-1:0]              d_den,
  input  logic [TAG_W-1:0]                     d_tag,
  output logic                                 q_valid,
  output logic [2*DATA_WIDTH+FRAC_BITS-1:0]    q_re,
  output logic [2*DATA_WIDTH+FRAC_BITS-1:0]    q_im,
  output logic [TAG_W-1:0]                     q_tag
);
  import cau_pkg::*;

  localparam int P  = 2 * DATA_WIDTH;
  localparam int QB = 2 * DATA_WIDTH + FRAC_BITS;

  // One restoring step: the dividend shifts out of the top of dq while
  // quotient bits shift in at the bottom.
  function automatic logic [P+QB-1:0] div_step(input logic [P-1:0]  rem,
                                               input logic [QB-1:0] dq,
                                               input logic [P-1:0]  den);
    logic [P:0] t;
    logic [P:0] diff;
    logic       ge;
    t    = {rem, dq[QB-1]};
    diff = t - {1'b0, den};
    ge   = (t >= {1'b0, den});
    return {(ge ? diff[P-1:0] : t[P-1:0]), dq[QB-2:0], ge};
  endfunction

  logic              v_r      [QB];
  logic [P-1:0]      rem_re_r [QB];
  logic [P-1:0]      rem_im_r [QB];
  logic [QB-1:0]     dq_re_r  [QB];
  logic [QB-1:0]     dq_im_r  [QB];
  logic [P-1:0]      den_r    [QB];
  logic [TAG_W-1:0]  tag_r    [QB];

  for (genvar k = 0; k < QB; k++) begin : g_stage
    logic              pv;
    logic [P-1:0]      prem_re, prem_im, pden;
    logic [QB-1:0]     pdq_re, pdq_im;
    logic [TAG_W-1:0]  ptag;
    logic [P+QB-1:0]   st_re, st_im;

    if (k == 0) begin : g_first
      assign pv      = d_valid;
      assign prem_re = '0;
      assign prem_im = '0;
      assign pdq_re  = {d_num_re, {FRAC_BITS{1'b0}}};
      assign pdq_im  = {d_num_im, {FRAC_BITS{1'b0}}};
      assign pden    = d_den;
      assign ptag    = d_tag;
    end else begin : g_next
      assign pv      = v_r[k-1];
      assign prem_re = rem_re_r[k-1];
      assign prem_im = rem_im_r[k-1];
      assign pdq_re  = dq_re_r[k-1];
      assign pdq_im  = dq_im_r[k-1];
      assign pden    = den_r[k-1];
      assign ptag    = tag_r[k-1];
    end

    assign st_re = div_step(prem_re, pdq_re, pden);
    assign st_im = div_step(prem_im, pdq_im, pden);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else begin
        v_r[k] <= pv;
      end
      rem_re_r[k] <= st_re[P+QB-1:QB];
      dq_re_r[k]  <= st_re[QB-1:0];
      rem_im_r[k] <= st_im[P+QB-1:QB];
      dq_im_r[k]  <= st_im[QB-1:0];
      den_r[k]    <= pden;
      tag_r[k]    <= ptag;
    end
  end

  assign q_valid = v_r[QB-1];
  assign q_re    = dq_re_r[QB-1];
  assign q_im    = dq_im_r[QB-1];
  assign q_tag   = tag_r[QB-1];
endmodule

@@ design/complex_arithmetic_unit.sv @@
`timescale 1ns / 1ps
// Fully pipelined complex ALU on signed fixed-point operands. A transaction is
// accepted on any cycle that start is high; busy is always low, because every
// operation takes the same path and the result side never stalls. Each result
// appears with out_valid after the front stages, the divider stages and the
// output register (default Q16.16), one result per cycle at full rate.
// The latency is set by the restoring divider, which resolves one quotient bit
// per pipeline stage; all other operations ride alongside it so results stay
// in order. Results are not held: sample them on the cycle out_valid is high.
`include "complex_arithmetic_unit_macros.svh"
module complex_arithmetic_unit #(
  parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = cau_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [cau_pkg::REQ_W-1:0]           in_req_type,
  input  logic signed [cau_pkg::PORT_W-1:0]   in_a_re,
  input  logic signed [cau_pkg::PORT_W-1:0]   in_a_im,
  input  logic signed [cau_pkg::PORT_W-1:0]   in_b_re,
  input  logic signed [cau_pkg::PORT_W-1:0]   in_b_im,
  output logic                                out_valid,
  output logic signed [cau_pkg::PORT_W-1:0]   out_res_re,
  output logic signed [cau_pkg::PORT_W-1:0]   out_res_im,
  output logic [cau_pkg::STAT_W-1:0]          out_status
);
  import cau_pkg::*;

  localparam int W     = DATA_WIDTH;
  localparam int P     = 2 * DATA_WIDTH;
  localparam int QB    = 2 * DATA_WIDTH + FRAC_BITS;
  localparam int CTL_W = $bits(cau_ctl_t);
  localparam int TAG_W = CTL_W + 2 * DATA_WIDTH;
  localparam int LAT   = QB + 5;

  logic          f_valid;
  cau_ctl_t      f_ctl;
  logic [W-1:0]  f_res_re, f_res_im;
  logic [P-1:0]  f_num_re, f_num_im, f_den;

  assign busy = 1'b0;

  cau_front #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (start),
    .in_req_type (in_req_type),
    .in_a_re     (in_a_re),
    .in_a_im     (in_a_im),
    .in_b_re     (in_b_re),
    .in_b_im     (in_b_im),
    .f_valid     (f_valid),
    .f_ctl       (f_ctl),
    .f_res_re    (f_res_re),
    .f_res_im    (f_res_im),
    .f_num_re    (f_num_re),
    .f_num_im    (f_num_im),
    .f_den       (f_den)
  );

  logic              q_valid;
  logic [QB-1:0]     q_re, q_im;
  logic [TAG_W-1:0]  q_tag;

  cau_divider #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS),
    .TAG_W      (TAG_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .d_valid  (f_valid),
    .d_num_re (f_num_re),
    .d_num_im (f_num_im),
    .d_den    (f_den),
    .d_tag    ({f_ctl, f_res_re, f_res_im}),
    .q_valid  (q_valid),
    .q_re     (q_re),
    .q_im     (q_im),
    .q_tag    (q_tag)
  );

  cau_ctl_t      t_ctl;
  logic [W-1:0]  t_re, t_im;
  assign t_ctl = q_tag[TAG_W-1:2*W];
  assign t_re  = q_tag[2*W-1:W];
  assign t_im  = q_tag[W-1:0];

  // Signed saturation of a quotient magnitude; the result is {flag, value}.
  function automatic logic [W:0] sat_q(input logic [QB-1:0] q, input logic neg);
    logic       ov;
    logic [W:0] r;
    if (neg) begin
      ov = (|q[QB-1:W]) || (q[W-1] && (|q[W-2:0]));
      r  = ov ? {2'b11, {(W-1){1'b0}}} : {1'b0, -q[W-1:0]};
    end else begin
      ov = |q[QB-1:W-1];
      r  = ov ? {2'b10, {(W-1){1'b1}}} : {1'b0, q[W-1:0]};
    end
    return r;
  endfunction

  logic [W:0]         dq_re, dq_im;
  logic [W-1:0]       res_re_nxt, res_im_nxt;
  logic [STAT_W-1:0]  status_nxt;

  assign dq_re = sat_q(q_re, t_ctl.neg_re);
  assign dq_im = sat_q(q_im, t_ctl.neg_im);

  always_comb begin
    res_re_nxt = t_re;
    res_im_nxt = t_im;
    status_nxt = t_ctl.status;
    if (t_ctl.is_div) begin
      if (t_ctl.dz) begin
        res_re_nxt = '0;
        res_im_nxt = '0;
        status_nxt = ST_DZ;
      end else begin
        res_re_nxt = dq_re[W-1:0];
        res_im_nxt = dq_im[W-1:0];
        status_nxt = (dq_re[W] || dq_im[W]) ? ST_SAT : ST_OK;
      end
    end
  end

  logic               out_valid_r;
  logic [W-1:0]       out_re_r, out_im_r;
  logic [STAT_W-1:0]  out_status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= q_valid;
    end
    out_re_r     <= res_re_nxt;
    out_im_r     <= res_im_nxt;
    out_status_r <= status_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_res_re = PORT_W'(signed'(out_re_r));
  assign out_res_im = PORT_W'(signed'(out_im_r));
  assign out_status = out_status_r;

  `CAU_ASSERT_IMP(a_fixed_latency, out_valid, $past(start, LAT), "result without a start")
  `CAU_ASSERT_IMP(a_dz_zero, out_valid && (out_status == ST_DZ),
                  (out_res_re == '0) && (out_res_im == '0), "divide by zero gave data")
  `CAU_ASSERT_IMP(a_status_code, out_valid,
                  (out_status == ST_OK) || (out_status == ST_SAT) || (out_status == ST_DZ),
                  "unknown status code")
endmodule
